// ===== sv/dss_pkg.sv =====
package dss_pkg;

  localparam int DEF_NUM_STEPS  = 16;
  localparam int DEF_ALT_STEPS  = 12;
  localparam int DEF_NUM_VOICES = 8;

  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int EV_QUEUE_DEPTH  = 4;

  localparam logic [23:0] PERIOD_RESET = 24'd133328;
  localparam logic [3:0]  VOICE_CHAN_RESET = 4'd9;
  localparam logic [6:0]  VOICE_NOTE_RESET = 7'd80;
  localparam logic [6:0]  VOICE_VEL_RESET  = 7'd127;

  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_PATTERN = 3'd1;
  localparam logic [2:0] OP_VOICE   = 3'd2;
  localparam logic [2:0] OP_RUN     = 3'd3;
  localparam logic [2:0] OP_SYNC    = 3'd4;

  localparam logic [1:0] REG_STEP_PERIOD = 2'd0;
  localparam logic [1:0] REG_LOOP_SELECT = 2'd1;
  localparam logic [1:0] REG_SYNC_ARMED  = 2'd2;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_PATTERN,
    CMD_VOICE,
    CMD_RUN_ON,
    CMD_RUN_OFF,
    CMD_SYNC
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [3:0]  step_index;
    logic [7:0]  hit_mask;
    logic [2:0]  voice_index;
    logic        voice_on;
    logic [3:0]  voice_channel;
    logic [6:0]  voice_note;
    logic [6:0]  voice_velocity;
  } cmd_t;

  typedef struct packed {
    logic        event_on;
    logic [3:0]  channel;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic [3:0]  step_now;
    logic        last;
  } event_t;

  typedef struct packed {
    logic [23:0] step_period;
    logic        loop_select;
    logic        sync_armed;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADVANCE,
    ST_SCAN
  } state_t;

endpackage

// ===== sv/dss_fifo.sv =====
module dss_fifo
  import dss_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count == '0);
  assign full    = (count == CW'(DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/dss_front.sv =====
module dss_front
  import dss_pkg::*;
#(
  parameter int NUM_STEPS  = DEF_NUM_STEPS,
  parameter int NUM_VOICES = DEF_NUM_VOICES
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       push,
  output logic       full,
  input  logic [2:0] op,
  input  logic [3:0] step_index,
  input  logic [7:0] hit_mask,
  input  logic [2:0] voice_index,
  input  logic       voice_on,
  input  logic [3:0] voice_channel,
  input  logic [6:0] voice_note,
  input  logic [6:0] voice_velocity,
  input  logic       run_enable,
  input  logic       cmd_pop,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  cmd_t                  cmd_in;
  logic                  keep;
  logic                  q_empty;
  logic [$bits(cmd_t)-1:0] q_rdata;

  always_comb begin
    cmd_in.kind           = CMD_TICK;
    cmd_in.step_index     = step_index;
    cmd_in.hit_mask       = hit_mask;
    cmd_in.voice_index    = voice_index;
    cmd_in.voice_on       = voice_on;
    cmd_in.voice_channel  = voice_channel;
    cmd_in.voice_note     = voice_note;
    cmd_in.voice_velocity = voice_velocity;
    keep = 1'b0;
    case (op)
      OP_TICK: begin
        cmd_in.kind = CMD_TICK;
        keep = 1'b1;
      end
      OP_PATTERN: begin
        cmd_in.kind = CMD_PATTERN;
        keep = (int'(step_index) < NUM_STEPS);
      end
      OP_VOICE: begin
        cmd_in.kind = CMD_VOICE;
        keep = (int'(voice_index) < NUM_VOICES);
      end
      OP_RUN: begin
        cmd_in.kind = run_enable ? CMD_RUN_ON : CMD_RUN_OFF;
        keep = 1'b1;
      end
      OP_SYNC: begin
        cmd_in.kind = CMD_SYNC;
        keep = cfg.sync_armed;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  dss_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push && keep),
    .wdata (cmd_in),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (full)
  );

  assign cmd_valid = !q_empty;
  assign cmd       = cmd_t'(q_rdata);

endmodule

// ===== sv/dss_back.sv =====
module dss_back
  import dss_pkg::*;
#(
  parameter int NUM_STEPS  = DEF_NUM_STEPS,
  parameter int ALT_STEPS  = DEF_ALT_STEPS,
  parameter int NUM_VOICES = DEF_NUM_VOICES
) (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  logic   cmd_valid,
  input  cmd_t   cmd,
  output logic   cmd_pop,
  input  logic   ev_full,
  output logic   ev_push,
  output event_t ev
);

  localparam int NV       = NUM_VOICES;
  localparam int SW       = $clog2(NUM_STEPS);
  localparam int VW       = (NV > 1) ? $clog2(NV) : 1;
  localparam int PS_DEPTH = (NUM_STEPS < 16) ? NUM_STEPS : 16;
  localparam int PSW      = $clog2(PS_DEPTH);
  localparam int ALT_LEN  = (ALT_STEPS > NUM_STEPS) ? NUM_STEPS : ALT_STEPS;
  localparam logic [SW:0] LEN_FULL = (SW + 1)'(NUM_STEPS);
  localparam logic [SW:0] LEN_ALT  = (SW + 1)'(ALT_LEN);

  state_t        state;
  state_t        state_next;
  logic [SW-1:0] cur;
  logic          running;
  logic [23:0]   countdown;
  logic [NV-1:0] pat [PS_DEPTH];
  logic [NV-1:0] v_on;
  logic [3:0]    v_chan [NV];
  logic [6:0]    v_note [NV];
  logic [6:0]    v_vel  [NV];
  logic [NV-1:0] off_mask;
  logic [NV-1:0] on_mask;
  logic [VW-1:0] vi;
  logic          half;

  logic [SW:0]   len;
  logic [SW:0]   step_inc;
  logic [SW-1:0] step_fire;
  logic [NV-1:0] hits_cur;
  logic          fire;
  logic          adv_zero;
  logic          scan_bit;
  logic          scan_go;
  logic [NV-1:0] off_clr;
  logic [NV-1:0] on_clr;
  logic          rest_zero;

  assign len       = cfg.loop_select ? LEN_ALT : LEN_FULL;
  assign step_inc  = (SW + 1)'(cur) + 1'b1;
  assign step_fire = (step_inc >= len) ? '0 : step_inc[SW-1:0];
  assign hits_cur  = (int'(cur) < PS_DEPTH) ? pat[cur[PSW-1:0]] : '0;
  assign fire      = cmd_pop && (cmd.kind == CMD_TICK) && running && (countdown <= 24'd1);
  assign adv_zero  = ((hits_cur & v_on) | off_mask) == '0;
  assign scan_bit  = half ? on_mask[vi] : off_mask[vi];
  assign scan_go   = !(scan_bit && ev_full);
  assign off_clr   = half ? off_mask : (off_mask & ~(NV'(1) << vi));
  assign on_clr    = half ? (on_mask & ~(NV'(1) << vi)) : on_mask;
  assign rest_zero = (off_clr | on_clr) == '0;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (fire) begin
          state_next = ST_ADVANCE;
        end else if (cmd_pop && (cmd.kind == CMD_RUN_OFF)) begin
          state_next = ST_SCAN;
        end
      end
      ST_ADVANCE: begin
        state_next = adv_zero ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_go && rest_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_pop     = (state == ST_IDLE) && cmd_valid;
    ev_push     = (state == ST_SCAN) && scan_bit && !ev_full;
    ev.event_on = half;
    ev.channel  = v_chan[vi];
    ev.note     = v_note[vi];
    ev.velocity = half ? v_vel[vi] : 7'd0;
    ev.step_now = 4'(cur);
    ev.last     = rest_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur       <= SW'(NUM_STEPS - 1);
      running   <= 1'b0;
      countdown <= 24'd1;
      off_mask  <= '0;
      on_mask   <= '0;
      vi        <= '0;
      half      <= 1'b0;
      v_on      <= '0;
      for (int i = 0; i < PS_DEPTH; i++) begin
        pat[i] <= '0;
      end
      for (int i = 0; i < NV; i++) begin
        v_chan[i] <= VOICE_CHAN_RESET;
        v_note[i] <= VOICE_NOTE_RESET;
        v_vel[i]  <= VOICE_VEL_RESET;
      end
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          if (cmd_pop) begin
            case (cmd.kind)
              CMD_TICK: begin
                if (running) begin
                  if (countdown <= 24'd1) begin
                    countdown <= (cfg.step_period == '0) ? 24'd1 : cfg.step_period;
                    off_mask  <= hits_cur & v_on;
                    cur       <= step_fire;
                  end else begin
                    countdown <= countdown - 1'b1;
                  end
                end
              end
              CMD_PATTERN: begin
                pat[cmd.step_index[PSW-1:0]] <= cmd.hit_mask[NV-1:0];
              end
              CMD_VOICE: begin
                v_on[cmd.voice_index[VW-1:0]]   <= cmd.voice_on;
                v_chan[cmd.voice_index[VW-1:0]] <= cmd.voice_channel;
                v_note[cmd.voice_index[VW-1:0]] <= cmd.voice_note;
                v_vel[cmd.voice_index[VW-1:0]]  <= cmd.voice_velocity;
              end
              CMD_RUN_ON: begin
                running <= 1'b1;
              end
              CMD_RUN_OFF: begin
                running  <= 1'b0;
                off_mask <= '1;
                on_mask  <= '0;
                vi       <= '0;
                half     <= 1'b0;
              end
              CMD_SYNC: begin
                cur       <= SW'(len - 1'b1);
                countdown <= 24'd1;
                running   <= 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADVANCE: begin
          on_mask <= hits_cur & v_on;
          vi      <= '0;
          half    <= 1'b0;
        end
        ST_SCAN: begin
          if (scan_go) begin
            off_mask <= off_clr;
            on_mask  <= on_clr;
            if (vi == VW'(NV - 1)) begin
              vi   <= '0;
              half <= 1'b1;
            end else begin
              vi <= vi + 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/drum_step_sequencer_core.sv =====
// Drum pattern step sequencer. Items enter through a two-entry command queue; the engine
// behind it takes one command per cycle when it is idle. A tick that fires a step moves
// the engine to an advance state and, if a note-off or note-on is pending, on to a scan
// of up to 2 * NUM_VOICES voice slots, note-offs first; a run disable scans at most
// NUM_VOICES slots. The scan stalls on a pending slot while the four-entry event queue
// is full. Every other item is handled in the idle state. Reset clears the pattern store
// and resets the voice table at once, so the block accepts items right after reset.
module drum_step_sequencer_core
  import dss_pkg::*;
#(
  parameter int NUM_STEPS  = DEF_NUM_STEPS,
  parameter int ALT_STEPS  = DEF_ALT_STEPS,
  parameter int NUM_VOICES = DEF_NUM_VOICES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  op,
  input  logic [3:0]  step_index,
  input  logic [7:0]  hit_mask,
  input  logic [2:0]  voice_index,
  input  logic        voice_on,
  input  logic [3:0]  voice_channel,
  input  logic [6:0]  voice_note,
  input  logic [6:0]  voice_velocity,
  input  logic        run_enable,
  output logic        empty,
  input  logic        pop,
  output logic        event_on,
  output logic [3:0]  channel,
  output logic [6:0]  note,
  output logic [6:0]  velocity,
  output logic [3:0]  step_now,
  output logic        last
);

  cfg_t   cfg;
  logic   cmd_valid;
  cmd_t   cmd;
  logic   cmd_pop;
  logic   ev_full;
  logic   ev_push;
  event_t ev;
  event_t ev_out;
  logic [$bits(event_t)-1:0] ev_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_period <= PERIOD_RESET;
      cfg.loop_select <= 1'b0;
      cfg.sync_armed  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_STEP_PERIOD: cfg.step_period <= cfg_data;
        REG_LOOP_SELECT: cfg.loop_select <= cfg_data[0];
        REG_SYNC_ARMED:  cfg.sync_armed  <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  dss_front #(
    .NUM_STEPS  (NUM_STEPS),
    .NUM_VOICES (NUM_VOICES)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .push           (push),
    .full           (full),
    .op             (op),
    .step_index     (step_index),
    .hit_mask       (hit_mask),
    .voice_index    (voice_index),
    .voice_on       (voice_on),
    .voice_channel  (voice_channel),
    .voice_note     (voice_note),
    .voice_velocity (voice_velocity),
    .run_enable     (run_enable),
    .cmd_pop        (cmd_pop),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd)
  );

  dss_back #(
    .NUM_STEPS  (NUM_STEPS),
    .ALT_STEPS  (ALT_STEPS),
    .NUM_VOICES (NUM_VOICES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .ev_full   (ev_full),
    .ev_push   (ev_push),
    .ev        (ev)
  );

  dss_fifo #(
    .WIDTH ($bits(event_t)),
    .DEPTH (EV_QUEUE_DEPTH)
  ) u_ev_q (
    .clk   (clk),
    .rst   (rst),
    .push  (ev_push),
    .wdata (ev),
    .pop   (pop),
    .rdata (ev_rdata),
    .empty (empty),
    .full  (ev_full)
  );

  assign ev_out   = event_t'(ev_rdata);
  assign event_on = ev_out.event_on;
  assign channel  = ev_out.channel;
  assign note     = ev_out.note;
  assign velocity = ev_out.velocity;
  assign step_now = ev_out.step_now;
  assign last     = ev_out.last;

endmodule

// ===== sv/dss_checker.sv =====
module dss_checker
  import dss_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       event_on,
  input logic [3:0] channel,
  input logic [6:0] note,
  input logic [6:0] velocity,
  input logic [3:0] step_now,
  input logic       last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("event queue not empty after reset");

  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("command queue full after reset");

  a_off_zero_vel: assert property (@(posedge clk) disable iff (rst)
    (!empty && !event_on) |-> (velocity == 7'd0))
    else $error("note-off with nonzero velocity");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(event_on) && $stable(channel) &&
      $stable(note) && $stable(velocity) && $stable(step_now) && $stable(last)))
    else $error("waiting event changed before transfer");

endmodule

bind drum_step_sequencer_core dss_checker u_dss_checker (.*);
